// ===== rtl/lbs_pkg.sv =====
// Shared types, constants and codes for the linear blend skinning unit.
package lbs_pkg;

	localparam int BONE_COUNT  = 128;
	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int ROW_COUNT   = 3;
	localparam int COL_COUNT   = 4;
	localparam int WORD_W      = 32;
	localparam int PAL_DEPTH   = BONE_COUNT * ROW_COUNT;
	localparam int PAL_AW      = $clog2(PAL_DEPTH);
	localparam int ROW_W       = WORD_W * COL_COUNT;

	localparam logic [65:0] RND_HALF = 66'(1) << (FRAC_BITS - 1);
	localparam logic [64:0] FIN_HALF = 65'(1) << (WEIGHT_BITS - 1);
	localparam logic [31:0] S32_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN  = 32'h8000_0000;
	localparam logic [63:0] S64_MAX  = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;

	typedef logic [PAL_AW-1:0] pal_addr_t;
	typedef logic [ROW_W-1:0]  pal_row_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_SKIN = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [6:0]         bone_index;
		logic [1:0]         matrix_row;
		logic               is_point;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] row_offset;
		logic [16:0]        weight;
		logic               last_influence;
	} lbs_req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               saturated;
	} lbs_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_ROUND,
		ST_WMUL,
		ST_ACC,
		ST_EMIT
	} lbs_state_t;

	typedef enum logic [1:0] {
		MUL_C0,
		MUL_C1,
		MUL_C2,
		MUL_W
	} mul_op_t;

	typedef enum logic [1:0] {
		SUM_HOLD,
		SUM_LOAD,
		SUM_ADD
	} sum_op_t;

	typedef struct packed {
		mul_op_t    mul_op;
		sum_op_t    sum_op;
		logic       round_en;
		logic       acc_en;
		logic       emit_en;
		logic [1:0] row;
		logic       zero_mat;
	} lbs_ctrl_t;

	function automatic pal_addr_t pal_addr(input logic [6:0] bone, input logic [1:0] row);
		return pal_addr_t'(bone) * pal_addr_t'(ROW_COUNT) + pal_addr_t'(row);
	endfunction

endpackage

// ===== rtl/lbs_palette_ram.sv =====
// Bone palette RAM: one write port, one read port with registered read data.
module lbs_palette_ram #(
	parameter int DEPTH = 384,
	parameter int WIDTH = 128,
	parameter int AW    = 9
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/lbs_row_unit.sv =====
// Skinning datapath: shared multiplier, row dot product, rounding, weighted accumulators.
module lbs_row_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  lbs_pkg::lbs_ctrl_t ctrl,
	input  lbs_pkg::pal_row_t  row_data,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic [16:0]        weight,
	input  logic               is_point,
	output lbs_pkg::lbs_rsp_t  result
);

	typedef struct packed {
		logic [31:0] val;
		logic        clip;
	} fin_t;

	function automatic fin_t finish(input logic signed [63:0] s);
		logic signed [64:0] f;
		logic signed [64:0] f_sh;
		logic               fits;
		fin_t               r;
		f    = 65'(s) + $signed(lbs_pkg::FIN_HALF);
		f_sh = f >>> lbs_pkg::WEIGHT_BITS;
		fits = (&f_sh[64:31]) | ~(|f_sh[64:31]);
		r.clip = ~fits;
		r.val  = fits ? f_sh[31:0] : (f_sh[64] ? lbs_pkg::S32_MIN : lbs_pkg::S32_MAX);
		return r;
	endfunction

	lbs_pkg::pal_row_t  row_m;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod_q;
	logic signed [65:0] dot_q;
	logic signed [31:0] t_q;
	logic signed [63:0] sum_x_q;
	logic signed [63:0] sum_y_q;
	logic signed [63:0] sum_z_q;
	logic               sat_q;

	logic signed [65:0] dot_rnd;
	logic signed [65:0] dot_sh;
	logic signed [31:0] off_sel;
	logic signed [66:0] tr;
	logic               tr_fits;
	logic [31:0]        t_clip;

	logic signed [63:0] acc_cur;
	logic signed [64:0] acc_sum;
	logic               acc_ovf;
	logic [63:0]        acc_new;

	fin_t fin_x;
	fin_t fin_y;
	fin_t fin_z;

	// bone beyond the palette reads as an all-zero matrix
	assign row_m = ctrl.zero_mat ? '0 : row_data;

	always_comb begin
		case (ctrl.mul_op)
			lbs_pkg::MUL_C0: begin
				mul_a = row_m[0*lbs_pkg::WORD_W +: lbs_pkg::WORD_W];
				mul_b = vec_x;
			end
			lbs_pkg::MUL_C1: begin
				mul_a = row_m[1*lbs_pkg::WORD_W +: lbs_pkg::WORD_W];
				mul_b = vec_y;
			end
			lbs_pkg::MUL_C2: begin
				mul_a = row_m[2*lbs_pkg::WORD_W +: lbs_pkg::WORD_W];
				mul_b = vec_z;
			end
			lbs_pkg::MUL_W: begin
				mul_a = t_q;
				mul_b = $signed({15'd0, weight});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		case (ctrl.sum_op)
			lbs_pkg::SUM_LOAD: dot_q <= 66'(prod_q);
			lbs_pkg::SUM_ADD:  dot_q <= dot_q + 66'(prod_q);
			default:           dot_q <= dot_q;
		endcase
	end

	// round half up to Q(FRAC_BITS), add translation for points, clip to 32 bits
	always_comb begin
		dot_rnd = dot_q + $signed(lbs_pkg::RND_HALF);
		dot_sh  = dot_rnd >>> lbs_pkg::FRAC_BITS;
		off_sel = is_point ? row_m[3*lbs_pkg::WORD_W +: lbs_pkg::WORD_W] : '0;
		tr      = 67'(dot_sh) + 67'(off_sel);
		tr_fits = (&tr[66:31]) | ~(|tr[66:31]);
		t_clip  = tr_fits ? tr[31:0] : (tr[66] ? lbs_pkg::S32_MIN : lbs_pkg::S32_MAX);
	end

	always_ff @(posedge clk) begin
		if (ctrl.round_en) begin
			t_q <= t_clip;
		end
	end

	always_comb begin
		case (ctrl.row)
			2'd0:    acc_cur = sum_x_q;
			2'd1:    acc_cur = sum_y_q;
			2'd2:    acc_cur = sum_z_q;
			default: acc_cur = '0;
		endcase
		acc_sum = 65'(acc_cur) + 65'(prod_q);
		acc_ovf = acc_sum[64] ^ acc_sum[63];
		acc_new = acc_ovf ? (acc_sum[64] ? lbs_pkg::S64_MIN : lbs_pkg::S64_MAX) : acc_sum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			sat_q   <= 1'b0;
		end else if (ctrl.emit_en) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			sat_q   <= 1'b0;
		end else begin
			if (ctrl.round_en && !tr_fits) begin
				sat_q <= 1'b1;
			end
			if (ctrl.acc_en) begin
				if (acc_ovf) begin
					sat_q <= 1'b1;
				end
				case (ctrl.row)
					2'd0:    sum_x_q <= acc_new;
					2'd1:    sum_y_q <= acc_new;
					2'd2:    sum_z_q <= acc_new;
					default: sum_x_q <= sum_x_q;
				endcase
			end
		end
	end

	assign fin_x = finish(sum_x_q);
	assign fin_y = finish(sum_y_q);
	assign fin_z = finish(sum_z_q);

	assign result.out_x     = fin_x.val;
	assign result.out_y     = fin_y.val;
	assign result.out_z     = fin_z.val;
	assign result.saturated = sat_q | fin_x.clip | fin_y.clip | fin_z.clip;

endmodule

// ===== rtl/linear_blend_vertex_skinning_unit.sv =====
// Top level of the linear blend skinning unit: handshakes, sequencer, palette and datapath.
// A palette load word is written straight into the palette RAM when it is taken, so loads
// stream at one per cycle while the sequencer is idle. For each of the three matrix rows
// of an influence word the sequencer reads the row from the 128-bit palette RAM, runs the
// three products through one shared 32x32 multiplier, sums them, rounds and clips, then
// runs the weight product through the same multiplier and adds it into the row's 64-bit
// accumulator. The vertex result sits in an output register, so the next word is taken
// while a result still waits; a last influence holds in its final cycle only while that
// register is full and stalled. Palette rows must be loaded before they are used.
module linear_blend_vertex_skinning_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  lbs_pkg::lbs_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lbs_pkg::lbs_rsp_t rsp_data
);

	lbs_pkg::lbs_state_t state_q;
	lbs_pkg::lbs_state_t state_d;
	lbs_pkg::lbs_req_t   item_q;
	logic [1:0]          row_q;
	logic [1:0]          row_d;
	logic                oob_q;
	logic                rsp_valid_q;
	lbs_pkg::lbs_rsp_t   rsp_q;

	lbs_pkg::lbs_ctrl_t  ctrl;
	lbs_pkg::lbs_rsp_t   result;
	lbs_pkg::pal_row_t   rd_data;
	logic                accept;
	logic                bone_ok;
	logic                wr_en;
	logic                rd_en;
	logic                out_free;

	assign req_stall = (state_q != lbs_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign bone_ok   = 32'(req_data.bone_index) < lbs_pkg::BONE_COUNT;
	assign wr_en     = accept && (req_data.action == lbs_pkg::ACT_LOAD) && bone_ok
	                   && (32'(req_data.matrix_row) < lbs_pkg::ROW_COUNT);
	assign rd_en     = (state_q == lbs_pkg::ST_READ);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	lbs_palette_ram #(
		.DEPTH(lbs_pkg::PAL_DEPTH),
		.WIDTH(lbs_pkg::ROW_W),
		.AW   (lbs_pkg::PAL_AW)
	) u_palette (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(lbs_pkg::pal_addr(req_data.bone_index, req_data.matrix_row)),
		.wr_data({req_data.row_offset, req_data.vec_z, req_data.vec_y, req_data.vec_x}),
		.rd_en  (rd_en),
		.rd_addr(lbs_pkg::pal_addr(item_q.bone_index, row_q)),
		.rd_data(rd_data)
	);

	lbs_row_unit u_row_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.row_data(rd_data),
		.vec_x   (item_q.vec_x),
		.vec_y   (item_q.vec_y),
		.vec_z   (item_q.vec_z),
		.weight  (item_q.weight),
		.is_point(item_q.is_point),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbs_pkg::ST_IDLE;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req_data;
			oob_q  <= !bone_ok;
		end
	end

	always_comb begin
		state_d       = state_q;
		row_d         = row_q;
		ctrl          = '0;
		ctrl.mul_op   = lbs_pkg::MUL_C0;
		ctrl.sum_op   = lbs_pkg::SUM_HOLD;
		ctrl.row      = row_q;
		ctrl.zero_mat = oob_q;
		case (state_q)
			lbs_pkg::ST_IDLE: begin
				if (accept && req_data.action == lbs_pkg::ACT_SKIN) begin
					row_d   = '0;
					state_d = lbs_pkg::ST_READ;
				end
			end
			lbs_pkg::ST_READ: begin
				state_d = lbs_pkg::ST_MUL0;
			end
			lbs_pkg::ST_MUL0: begin
				ctrl.mul_op = lbs_pkg::MUL_C0;
				state_d     = lbs_pkg::ST_MUL1;
			end
			lbs_pkg::ST_MUL1: begin
				ctrl.mul_op = lbs_pkg::MUL_C1;
				ctrl.sum_op = lbs_pkg::SUM_LOAD;
				state_d     = lbs_pkg::ST_MUL2;
			end
			lbs_pkg::ST_MUL2: begin
				ctrl.mul_op = lbs_pkg::MUL_C2;
				ctrl.sum_op = lbs_pkg::SUM_ADD;
				state_d     = lbs_pkg::ST_SUM;
			end
			lbs_pkg::ST_SUM: begin
				ctrl.sum_op = lbs_pkg::SUM_ADD;
				state_d     = lbs_pkg::ST_ROUND;
			end
			lbs_pkg::ST_ROUND: begin
				ctrl.round_en = 1'b1;
				state_d       = lbs_pkg::ST_WMUL;
			end
			lbs_pkg::ST_WMUL: begin
				ctrl.mul_op = lbs_pkg::MUL_W;
				state_d     = lbs_pkg::ST_ACC;
			end
			lbs_pkg::ST_ACC: begin
				ctrl.acc_en = 1'b1;
				if (32'(row_q) == lbs_pkg::ROW_COUNT - 1) begin
					state_d = item_q.last_influence ? lbs_pkg::ST_EMIT : lbs_pkg::ST_IDLE;
				end else begin
					row_d   = row_q + 2'd1;
					state_d = lbs_pkg::ST_READ;
				end
			end
			lbs_pkg::ST_EMIT: begin
				if (out_free) begin
					ctrl.emit_en = 1'b1;
					state_d      = lbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.emit_en) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_en) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the skinning unit: a directed table, then random vertices, checked word by word.
module tb_top;
	import lbs_pkg::*;

	localparam int          QUIET_LIMIT = 2000;
	localparam int          WORD_TARGET = 1350;
	localparam logic [31:0] Q_ONE       = 32'h0001_0000;
	localparam logic [31:0] MAT_SPAN    = 32'h0002_0000;
	localparam logic [31:0] VEC_SPAN    = 32'h0010_0000;
	localparam logic [31:0] OFF_SPAN    = 32'h0040_0000;

	typedef struct {
		lbs_req_t word;
		bit       typed;
		lbs_rsp_t want;
	} dir_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	lbs_req_t req_data  = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	lbs_rsp_t rsp_data;

	bit       cur_typed = 1'b0;
	lbs_rsp_t cur_want  = '0;
	bit       idle_on   = 1'b1;

	logic signed [31:0] pal [BONE_COUNT][ROW_COUNT][COL_COUNT];
	longint             blend_sum [3] = '{0, 0, 0};
	bit                 blend_sat     = 1'b0;
	lbs_rsp_t           skinned_q [$];
	int                 bad_fields    = 0;
	int                 quiet_cycles  = 0;
	bit [2:0]           rows_done [BONE_COUNT];
	bit                 bone_ready [BONE_COUNT];
	int                 ready_bones [$];
	int                 words_sent    = 0;
	dir_row_t           dir_tbl [$];

	linear_blend_vertex_skinning_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic longint clip32(input longint x, inout bit flag);
		if (x > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint sat_add64(input longint a, input longint b, inout bit flag);
		if (b > 0 && a > 64'sh7fff_ffff_ffff_ffff - b) begin
			flag = 1'b1;
			return 64'sh7fff_ffff_ffff_ffff;
		end
		if (b < 0 && a < 64'sh8000_0000_0000_0000 - b) begin
			flag = 1'b1;
			return 64'sh8000_0000_0000_0000;
		end
		return a + b;
	endfunction

	// one matrix row times the vector, rounded half up, plus translation for points
	function automatic longint xform_row(input int b, input int r, input lbs_req_t w,
	                                     inout bit flag);
		logic signed [31:0] v [3];
		longint             hi;
		longint             lo;
		longint             p;
		longint             acc;
		v[0] = w.vec_x;
		v[1] = w.vec_y;
		v[2] = w.vec_z;
		hi = 0;
		lo = 0;
		for (int c = 0; c < 3; c++) begin
			p = longint'(pal[b][r][c]) * longint'(v[c]);
			hi += p >>> FRAC_BITS;
			lo += p & ((64'sd1 <<< FRAC_BITS) - 64'sd1);
		end
		acc = hi + ((lo + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
		if (w.is_point)
			acc += longint'(pal[b][r][3]);
		return clip32(acc, flag);
	endfunction

	function automatic logic [31:0] round_out(input longint s, inout bit flag);
		longint hi;
		longint lo;
		hi = s >>> WEIGHT_BITS;
		lo = s & 64'sd65535;
		return 32'(clip32(hi + ((lo + 64'sd32768) >>> WEIGHT_BITS), flag));
	endfunction

	// applies one word to the local palette and sums; returns 1 when a vertex is done
	function automatic bit blend_word(input lbs_req_t w, output lbs_rsp_t r);
		longint t;
		bit     flag;
		r = '0;
		if (w.action == ACT_LOAD) begin
			if (w.matrix_row < ROW_COUNT && int'(w.bone_index) < BONE_COUNT) begin
				pal[w.bone_index][w.matrix_row][0] = w.vec_x;
				pal[w.bone_index][w.matrix_row][1] = w.vec_y;
				pal[w.bone_index][w.matrix_row][2] = w.vec_z;
				pal[w.bone_index][w.matrix_row][3] = w.row_offset;
			end
			return 1'b0;
		end
		for (int k = 0; k < 3; k++) begin
			t = xform_row(w.bone_index, k, w, blend_sat);
			blend_sum[k] = sat_add64(blend_sum[k], t * longint'(w.weight), blend_sat);
		end
		if (!w.last_influence)
			return 1'b0;
		flag = blend_sat;
		r.out_x = round_out(blend_sum[0], flag);
		r.out_y = round_out(blend_sum[1], flag);
		r.out_z = round_out(blend_sum[2], flag);
		r.saturated = flag;
		blend_sum = '{0, 0, 0};
		blend_sat = 1'b0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			bad_fields++;
			$display("%0t %s: expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : mon
		lbs_rsp_t vtx;
		quiet_cycles++;
		if (arst_n && req_valid && !req_stall) begin
			quiet_cycles = 0;
			if (blend_word(req_data, vtx))
				skinned_q.push_back(cur_typed ? cur_want : vtx);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			quiet_cycles = 0;
			if (skinned_q.size() == 0) begin
				bad_fields++;
				$display("%0t vertex word: expected none, got %h", $time, rsp_data);
			end else begin
				vtx = skinned_q.pop_front();
				check_field("out_x", vtx.out_x, rsp_data.out_x);
				check_field("out_y", vtx.out_y, rsp_data.out_y);
				check_field("out_z", vtx.out_z, rsp_data.out_z);
				check_field("saturated", 32'(vtx.saturated), 32'(rsp_data.saturated));
			end
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic logic [31:0] pick_val(input logic [31:0] span);
		case ($urandom_range(0, 15))
			0: return $urandom();
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h0;
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65536;
			2: return int'(17'($urandom()));
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic lbs_req_t load_word(input int bone, input int row,
	                                       input logic [31:0] x, y, z, off);
		lbs_req_t w;
		w = '0;
		w.action         = ACT_LOAD;
		w.bone_index     = 7'(bone);
		w.matrix_row     = 2'(row);
		w.is_point       = 1'($urandom());
		w.vec_x          = x;
		w.vec_y          = y;
		w.vec_z          = z;
		w.row_offset     = off;
		w.weight         = 17'($urandom());
		w.last_influence = ($urandom_range(0, 7) == 0);
		return w;
	endfunction

	function automatic lbs_req_t skin_word(input int bone, input bit pt,
	                                       input logic [31:0] x, y, z,
	                                       input int wt, input bit last);
		lbs_req_t w;
		w = '0;
		w.action         = ACT_SKIN;
		w.bone_index     = 7'(bone);
		w.matrix_row     = 2'($urandom());
		w.is_point       = pt;
		w.vec_x          = x;
		w.vec_y          = y;
		w.vec_z          = z;
		w.row_offset     = $urandom();
		w.weight         = 17'(wt);
		w.last_influence = last;
		return w;
	endfunction

	function automatic lbs_rsp_t rsp_of(input logic [31:0] x, y, z, input bit s);
		lbs_rsp_t r;
		r.out_x     = x;
		r.out_y     = y;
		r.out_z     = z;
		r.saturated = s;
		return r;
	endfunction

	function automatic void add_row(input lbs_req_t w, input bit typed = 1'b0,
	                                input lbs_rsp_t want = '0);
		dir_row_t d;
		d.word  = w;
		d.typed = typed;
		d.want  = want;
		dir_tbl.push_back(d);
	endfunction

	task automatic send_word(input lbs_req_t w, input bit typed = 1'b0,
	                         input lbs_rsp_t want = '0);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= w;
		cur_typed <= typed;
		cur_want  <= want;
		do @(posedge clk); while (req_stall);
		if (w.action == ACT_LOAD && w.matrix_row < ROW_COUNT) begin
			rows_done[w.bone_index][w.matrix_row] = 1'b1;
			if (&rows_done[w.bone_index] && !bone_ready[w.bone_index]) begin
				bone_ready[w.bone_index] = 1'b1;
				ready_bones.push_back(int'(w.bone_index));
			end
		end
		if (!(w.action == ACT_LOAD && w.matrix_row >= ROW_COUNT))
			words_sent++;
	endtask

	task automatic load_bone(input int b);
		for (int r = 0; r < ROW_COUNT; r++)
			send_word(load_word(b, r, pick_val(MAT_SPAN), pick_val(MAT_SPAN),
			                    pick_val(MAT_SPAN), pick_val(OFF_SPAN)));
	endtask

	// one vertex: 1..4 influences on loaded bones, mostly weights that add up to one
	task automatic send_vertex();
		int  n;
		int  rem;
		int  wt;
		int  b;
		bit  split;
		n = $urandom_range(1, 4);
		split = ($urandom_range(0, 4) != 0);
		rem = 65536;
		for (int i = 0; i < n; i++) begin
			if (split) begin
				wt = (i == n - 1) ? rem : $urandom_range(0, rem);
				rem -= wt;
			end else begin
				wt = pick_weight();
			end
			b = ready_bones[$urandom_range(0, ready_bones.size() - 1)];
			send_word(skin_word(b, 1'($urandom()), pick_val(VEC_SPAN), pick_val(VEC_SPAN),
			                    pick_val(VEC_SPAN), wt, i == n - 1));
			if (i != n - 1 && $urandom_range(0, 9) == 0)
				send_word(load_word($urandom_range(0, BONE_COUNT - 1), $urandom_range(0, 2),
				                    pick_val(MAT_SPAN), pick_val(MAT_SPAN),
				                    pick_val(MAT_SPAN), pick_val(OFF_SPAN)));
		end
	endtask

	initial begin
		lbs_req_t w;
		// bone 0: identity with translation (5, 6, 7)
		for (int r = 0; r < 3; r++)
			add_row(load_word(0, r, r == 0 ? Q_ONE : 32'h0, r == 1 ? Q_ONE : 32'h0,
			                  r == 2 ? Q_ONE : 32'h0, (5 + r) << 16));
		add_row(skin_word(0, 1'b1, 32'h1_0000, 32'h2_0000, 32'h3_0000, 65536, 1'b1), 1'b1,
		        rsp_of(32'h6_0000, 32'h8_0000, 32'ha_0000, 1'b0));
		add_row(skin_word(0, 1'b0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 65536, 1'b1), 1'b1,
		        rsp_of(32'h1_0000, 32'h2_0000, 32'h3_0000, 1'b0));
		// row 3 is dropped, a load marked last gives no word
		add_row(load_word(0, 3, $urandom(), $urandom(), $urandom(), $urandom()));
		w = load_word(0, 0, Q_ONE, 32'h0, 32'h0, 32'h5_0000);
		w.last_influence = 1'b1;
		add_row(w);
		add_row(skin_word(0, 1'b1, 32'h1_0000, 32'h2_0000, 32'h3_0000, 65536, 1'b1), 1'b1,
		        rsp_of(32'h6_0000, 32'h8_0000, 32'ha_0000, 1'b0));
		// vertex with zero weight
		add_row(skin_word(0, 1'b1, 32'h1_0000, 32'h2_0000, 32'h3_0000, 0, 1'b1), 1'b1,
		        rsp_of(32'h0, 32'h0, 32'h0, 1'b0));
		for (int r = 0; r < 3; r++)
			add_row(load_word(127, r, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			                  32'h7fff_ffff));
		add_row(skin_word(127, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 65536, 1'b1),
		        1'b1, rsp_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
		for (int r = 0; r < 3; r++)
			add_row(load_word(1, r, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			                  32'h8000_0000));
		add_row(skin_word(1, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 131071, 1'b0));
		add_row(skin_word(1, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 65536, 1'b1));
		// sum past the output range
		add_row(skin_word(127, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 65536, 1'b0));
		add_row(skin_word(127, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 65536, 1'b1),
		        1'b1, rsp_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
		// half-up rounding on a 0.5 diagonal
		for (int r = 0; r < 3; r++)
			add_row(load_word(2, r, r == 0 ? 32'h8000 : 32'h0, r == 1 ? 32'h8000 : 32'h0,
			                  r == 2 ? 32'h8000 : 32'h0, 32'h0));
		add_row(skin_word(2, 1'b0, 32'd1, 32'hffff_ffff, 32'd3, 65536, 1'b1), 1'b1,
		        rsp_of(32'd1, 32'd0, 32'd2, 1'b0));

		wait (arst_n);
		@(posedge clk);
		foreach (dir_tbl[i])
			send_word(dir_tbl[i].word, dir_tbl[i].typed, dir_tbl[i].want);

		for (int i = 0; i < 12; i++)
			load_bone($urandom_range(0, BONE_COUNT - 1));
		while (words_sent < WORD_TARGET) begin
			idle_on = (words_sent < 600 || words_sent >= 750) && words_sent < 1150;
			case ($urandom_range(0, 9))
				0, 1: load_bone($urandom_range(0, BONE_COUNT - 1));
				2: send_word(load_word($urandom_range(0, BONE_COUNT - 1), 3, $urandom(),
				                       $urandom(), $urandom(), $urandom()));
				default: send_vertex();
			endcase
		end

		req_valid <= 1'b0;
		idle_on = 1'b0;
		while (skinned_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (bad_fields == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
